// ===== design/mtse_pkg.sv =====
// Shared types and constants for the Mach-O __text section extractor.
// No dependencies; every design file imports this package.
package mtse_pkg;

    localparam int POS_BITS = 32;
    localparam logic [POS_BITS-1:0] POS_MASK = {POS_BITS{1'b1}};

    localparam logic [31:0] MAGIC64       = 32'hfeedfacf;
    localparam logic [31:0] CPU_X86_64    = 32'h01000007;
    localparam logic [31:0] FILE_EXEC     = 32'd2;
    localparam logic [31:0] CMD_SEGMENT64 = 32'h19;
    localparam logic [7:0]  SEG_REC_LAST  = 8'd71;
    localparam logic [7:0]  SECT_REC_LAST = 8'd79;
    localparam int          HDR_LEN       = 32;

    localparam logic [47:0] SEGMENT_LABEL = {"TXET", "__"};
    localparam logic [47:0] SECT_NAME     = {"txet", "__"};

    localparam logic [1:0] ST_FOUND     = 2'd0;
    localparam logic [1:0] ST_BAD_HDR   = 2'd1;
    localparam logic [1:0] ST_NO_TEXT   = 2'd2;
    localparam logic [1:0] ST_TRUNCATED = 2'd3;

    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = 2;

    localparam int OUT_DATA_BITS = 240;

    // One queue word: an optional text byte followed by an optional report.
    typedef struct packed {
        logic        has_text;
        logic [7:0]  text_byte;
        logic [63:0] text_address;
        logic        has_report;
        logic [1:0]  status;
        logic [31:0] offset;
        logic [63:0] size;
        logic [63:0] load_address;
    } t_entry;

    // Name byte k of a 6-character name, zero for the terminator position.
    function automatic logic [7:0] name_char(input logic [47:0] name, input logic [2:0] k);
        logic [7:0] c;
        c = 8'd0;
        case (k)
            3'd0: c = name[7:0];
            3'd1: c = name[15:8];
            3'd2: c = name[23:16];
            3'd3: c = name[31:24];
            3'd4: c = name[39:32];
            3'd5: c = name[47:40];
            default: c = 8'd0;
        endcase
        return c;
    endfunction

endpackage

// ===== design/mtse_front.sv =====
// Front part: parses the byte stream and classifies each byte.
// Depends on mtse_pkg; pushes words into mtse_queue.
module mtse_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  logic [7:0]     i_data_byte,
    input  logic           i_last_byte,
    input  logic           i_q_ready,
    output logic           o_push,
    output mtse_pkg::t_entry o_entry
);
    import mtse_pkg::*;

    typedef enum logic [2:0] {
        PH_HEADER, PH_SEEK, PH_COMMAND, PH_SECTION, PH_TEXT, PH_END
    } t_phase;

    t_phase              r_phase, n_phase;
    logic [POS_BITS-1:0] r_pos, n_pos;
    logic [63:0]         r_acc, n_acc;
    logic [31:0]         r_cmds, n_cmds;
    logic [POS_BITS-1:0] r_next, n_next;
    logic [31:0]         r_sects, n_sects;
    logic [7:0]          r_idx, n_idx;
    logic                r_match, n_match;
    logic                r_found, n_found;
    logic [31:0]         r_foff, n_foff;
    logic [63:0]         r_fsize, n_fsize;
    logic [63:0]         r_faddr, n_faddr;
    logic [1:0]          r_status, n_status;

    logic   accept;
    t_entry n_entry;

    assign o_ready = i_q_ready;
    assign accept  = i_valid & i_q_ready;

    always_comb begin
        logic [31:0]         w32;
        logic [POS_BITS-1:0] pos;
        logic [7:0]          i;
        logic [63:0]         d;
        logic [64:0]         sum;
        logic                fin;
        n_phase  = r_phase;
        n_pos    = r_pos;
        n_acc    = r_acc;
        n_cmds   = r_cmds;
        n_next   = r_next;
        n_sects  = r_sects;
        n_idx    = r_idx;
        n_match  = r_match;
        n_found  = r_found;
        n_foff   = r_foff;
        n_fsize  = r_fsize;
        n_faddr  = r_faddr;
        n_status = r_status;
        n_entry  = '0;
        pos = r_pos;
        fin = 1'b0;
        i   = 8'd0;
        d   = 64'd0;
        sum = 65'd0;

        n_acc = {i_data_byte, r_acc[63:8]};
        w32   = n_acc[63:32];

        unique case (r_phase)
            PH_HEADER: begin
                if (pos == POS_BITS'(3) && w32 != MAGIC64) begin
                    n_phase = PH_END; n_status = ST_BAD_HDR;
                end else if (pos == POS_BITS'(7) && w32 != CPU_X86_64) begin
                    n_phase = PH_END; n_status = ST_BAD_HDR;
                end else if (pos == POS_BITS'(15) && w32 != FILE_EXEC) begin
                    n_phase = PH_END; n_status = ST_BAD_HDR;
                end else if (pos == POS_BITS'(19)) begin
                    n_cmds = w32;
                end else if (pos == POS_BITS'(HDR_LEN - 1)) begin
                    n_next = POS_BITS'(HDR_LEN);
                    if (n_cmds == 32'd0) begin
                        n_phase = PH_END; n_status = ST_NO_TEXT;
                    end else begin
                        n_phase = PH_SEEK;
                    end
                end
            end
            PH_SEEK: begin
                if (pos == r_next) begin
                    n_phase = PH_COMMAND;
                    n_idx   = 8'd0;
                end
            end
            PH_SECTION: begin
                i     = r_idx;
                n_idx = r_idx + 8'd1;
                if (i < 8'd6) begin
                    if (i_data_byte != name_char(SECT_NAME, i[2:0])) n_match = 1'b0;
                end else if (i == 8'd6) begin
                    if (i_data_byte != 8'd0) n_match = 1'b0;
                end
                if (n_match) begin
                    if (i == 8'd39) begin
                        n_faddr = n_acc;
                    end else if (i == 8'd47) begin
                        n_fsize = n_acc;
                    end else if (i == 8'd51) begin
                        n_foff  = w32;
                        n_found = 1'b1;
                        n_phase = PH_TEXT;
                        if (n_fsize == 64'd0 || (64'(pos) >= 64'(w32) &&
                            64'(pos) - 64'(w32) >= n_fsize - 64'd1)) begin
                            n_phase = PH_END; n_status = ST_FOUND;
                        end
                    end
                end
                if (n_phase == PH_SECTION && i == SECT_REC_LAST) begin
                    n_sects = r_sects - 32'd1;
                    if (n_sects == 32'd0) begin
                        fin = 1'b1;
                    end else begin
                        n_idx   = 8'd0;
                        n_match = 1'b1;
                    end
                end
            end
            PH_TEXT: begin
                if (64'(pos) >= 64'(r_foff)) begin
                    d = 64'(pos) - 64'(r_foff);
                    if (d < r_fsize) begin
                        n_entry.has_text     = 1'b1;
                        n_entry.text_byte    = i_data_byte;
                        n_entry.text_address = r_faddr + d;
                    end
                    if (d >= r_fsize - 64'd1) begin
                        n_phase = PH_END; n_status = ST_FOUND;
                    end
                end
            end
            PH_COMMAND, PH_END: ;
            default: ;
        endcase

        // command record, also entered in the cycle the seek hits its start
        if (n_phase == PH_COMMAND) begin
            i     = n_idx;
            n_idx = n_idx + 8'd1;
            if (i == 8'd3) begin
                n_match = (w32 == CMD_SEGMENT64);
            end else if (i == 8'd7) begin
                sum = 65'(n_next) + 65'(w32);
                if (sum > 65'(POS_MASK)) n_next = '0;
                else n_next = POS_BITS'(sum);
                if (!n_match) fin = 1'b1;
            end else if (i >= 8'd8 && i < 8'd24) begin
                if (i < 8'd14) begin
                    if (i_data_byte != name_char(SEGMENT_LABEL, 3'(i - 8'd8))) n_match = 1'b0;
                end else if (i == 8'd14) begin
                    if (i_data_byte != 8'd0) n_match = 1'b0;
                end
                if (i == 8'd23 && !n_match) fin = 1'b1;
            end else if (i == 8'd67) begin
                n_sects = w32;
            end else if (i == SEG_REC_LAST) begin
                if (n_sects == 32'd0) begin
                    fin = 1'b1;
                end else begin
                    n_phase = PH_SECTION;
                    n_idx   = 8'd0;
                    n_match = 1'b1;
                end
            end
        end

        // close a command: seek the next one or stop the walk
        if (fin) begin
            n_cmds = n_cmds - 32'd1;
            if (n_cmds == 32'd0 || n_next <= pos) begin
                n_phase = PH_END; n_status = ST_NO_TEXT;
            end else begin
                n_phase = PH_SEEK;
            end
        end

        n_pos = pos + POS_BITS'(1);

        if (i_last_byte) begin
            n_entry.has_report = 1'b1;
            n_entry.status     = (n_phase == PH_END) ? n_status : ST_TRUNCATED;
            n_entry.offset       = n_found ? n_foff  : 32'd0;
            n_entry.size         = n_found ? n_fsize : 64'd0;
            n_entry.load_address = n_found ? n_faddr : 64'd0;
            n_phase  = PH_HEADER;
            n_pos    = '0;
            n_acc    = '0;
            n_cmds   = '0;
            n_next   = '0;
            n_sects  = '0;
            n_idx    = '0;
            n_match  = 1'b1;
            n_found  = 1'b0;
            n_foff   = '0;
            n_fsize  = '0;
            n_faddr  = '0;
            n_status = '0;
        end
    end

    assign o_push  = accept & (n_entry.has_text | n_entry.has_report);
    assign o_entry = n_entry;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HEADER;
            r_pos    <= '0;
            r_acc    <= '0;
            r_cmds   <= '0;
            r_next   <= '0;
            r_sects  <= '0;
            r_idx    <= '0;
            r_match  <= 1'b1;
            r_found  <= 1'b0;
            r_foff   <= '0;
            r_fsize  <= '0;
            r_faddr  <= '0;
            r_status <= '0;
        end else if (accept) begin
            r_phase  <= n_phase;
            r_pos    <= n_pos;
            r_acc    <= n_acc;
            r_cmds   <= n_cmds;
            r_next   <= n_next;
            r_sects  <= n_sects;
            r_idx    <= n_idx;
            r_match  <= n_match;
            r_found  <= n_found;
            r_foff   <= n_foff;
            r_fsize  <= n_fsize;
            r_faddr  <= n_faddr;
            r_status <= n_status;
        end
    end

endmodule

// ===== design/mtse_queue.sv =====
// Short queue between the parser and the output stage.
// Depends on mtse_pkg for the word type and depth.
module mtse_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  mtse_pkg::t_entry i_entry,
    output logic             o_ready,
    input  logic             i_pop,
    output logic             o_valid,
    output mtse_pkg::t_entry o_entry
);
    import mtse_pkg::*;

    t_entry          r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wr, r_rd;
    logic [Q_AW:0]   r_cnt;

    assign o_ready = (r_cnt != (Q_AW+1)'(Q_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_entry = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_entry;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wr <= r_wr + Q_AW'(1);
            if (i_pop)  r_rd <= r_rd + Q_AW'(1);
            r_cnt <= r_cnt + (Q_AW+1)'(i_push) - (Q_AW+1)'(i_pop);
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (o_ready || i_pop)) else $error("queue push while full");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid) else $error("queue pop while empty");
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (Q_AW+1)'(Q_DEPTH)) else $error("queue count out of range");
`endif

endmodule

// ===== design/mtse_back.sv =====
// Back part: drains queue words into the registered output stream.
// Depends on mtse_pkg; fed by mtse_queue.
module mtse_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_valid,
    input  mtse_pkg::t_entry i_entry,
    output logic             o_pop,
    output logic             o_valid,
    input  logic             i_ready,
    output logic             o_kind,
    output logic [mtse_pkg::OUT_DATA_BITS-1:0] o_data
);
    import mtse_pkg::*;

    logic                     r_valid;
    logic                     r_kind;
    logic [OUT_DATA_BITS-1:0] r_data;
    logic                     r_text_sent;
    logic                     load, send_text;

    assign load      = i_q_valid & (~r_valid | i_ready);
    assign send_text = i_entry.has_text & ~r_text_sent;
    // pop once the word's last part goes out
    assign o_pop     = load & (~send_text | ~i_entry.has_report);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= 1'b0;
            r_text_sent <= 1'b0;
        end else begin
            if (load) r_valid <= 1'b1;
            else if (i_ready) r_valid <= 1'b0;
            if (load) r_text_sent <= send_text & i_entry.has_report;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            if (send_text) begin
                r_kind <= 1'b0;
                r_data <= {168'd0, i_entry.text_address, i_entry.text_byte};
            end else begin
                r_kind <= 1'b1;
                r_data <= {6'd0, i_entry.load_address, i_entry.size, i_entry.offset,
                           i_entry.status, 72'd0};
            end
        end
    end

    assign o_valid = r_valid;
    assign o_kind  = r_kind;
    assign o_data  = r_data;

`ifndef SYNTHESIS
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !i_ready) |=> ($stable(r_data) && $stable(r_kind)))
        else $error("output word changed while stalled");
    a_split: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_text_sent |-> (i_q_valid && i_entry.has_report))
        else $error("pending report missing from queue head");
    a_text_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load && send_text && i_entry.has_report) |-> !o_pop)
        else $error("word popped before its report");
`endif

endmodule

// ===== design/macho_text_section_extractor_top.sv =====
// Mach-O 64 __text section extractor: one file byte per cycle in while the queue has room, text bytes and a report out.
// Throughput: one byte per cycle while the queue has room; a final byte that also yields a text
// byte is sent as a text word and then a report word. Path: parser, queue, output register.
// A four-word queue decouples the parser from output backpressure.
// Reset (i_rst_n low, synchronous) clears parser state, queue and output; the last byte
// of a file also returns the parser to its reset state.
module macho_text_section_extractor_top (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,   // [7:0] data_byte
    input  logic         s_axis_tlast,   // last_byte
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [7:0] text_byte, [71:8] text_address, [73:72] status, [105:74] text_file_offset,
    // [169:106] text_size, [233:170] text_load_address, [239:234] zero
    output logic [mtse_pkg::OUT_DATA_BITS-1:0] m_axis_tdata,
    output logic         m_axis_tuser    // kind
);
    import mtse_pkg::*;

    logic   q_ready, push, pop, q_valid;
    t_entry push_entry, head_entry;

    mtse_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_data_byte (s_axis_tdata),
        .i_last_byte (s_axis_tlast),
        .i_q_ready   (q_ready),
        .o_push      (push),
        .o_entry     (push_entry)
    );

    mtse_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .o_ready (q_ready),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_entry (head_entry)
    );

    mtse_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_entry   (head_entry),
        .o_pop     (pop),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_kind    (m_axis_tuser),
        .o_data    (m_axis_tdata)
    );

endmodule

// ===== tb/tb.sv =====
// Self-checking bench for macho_text_section_extractor_top: builds small Mach-O 64 images,
// streams them byte by byte and checks every text byte and report against its own parser.
// Depends on mtse_pkg and the extractor RTL.
module tb;
    import mtse_pkg::*;

    localparam int LIMIT_CYCLES = 1_000_000;
    localparam int RAND_ITEMS   = 1350;

    typedef enum logic [2:0] {
        PH_HEADER, PH_SEEK, PH_COMMAND, PH_SECTION, PH_TEXT, PH_END
    } t_walk;

    typedef struct {
        logic [7:0] b;
        logic       lst;
        bit         drain;
    } t_file_byte;

    typedef struct {
        logic        kind;
        logic [7:0]  text_byte;
        logic [63:0] text_address;
        logic [1:0]  status;
        logic [31:0] offset;
        logic [63:0] size;
        logic [63:0] load_address;
    } t_out_word;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [7:0] s_axis_tdata = 8'd0;    // [7:0] data_byte
    logic s_axis_tlast = 1'b0;          // last_byte
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    // [7:0] text_byte, [71:8] text_address, [73:72] status, [105:74] text_file_offset,
    // [169:106] text_size, [233:170] text_load_address
    logic [OUT_DATA_BITS-1:0] m_axis_tdata;
    logic m_axis_tuser;                 // kind

    macho_text_section_extractor_top u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tlast (s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    t_file_byte  file_q[$];
    t_out_word   words_due[$];
    logic [7:0]  img[$];
    int          n_err = 0;
    int          n_rand = 0;
    int unsigned cyc = 0;

    // parser state
    logic [POS_BITS-1:0] w_pos;
    t_walk               w_phase;
    logic [63:0]         w_acc;
    logic [31:0]         w_cmds_left;
    logic [63:0]         w_next_cmd;
    logic [31:0]         w_sects_left;
    logic [7:0]          w_rec_idx;
    logic                w_match;
    logic                w_found;
    logic [31:0]         w_off;
    logic [63:0]         w_size;
    logic [63:0]         w_addr;
    logic [1:0]          w_status;

    task automatic walk_reset();
        w_pos = '0;
        w_phase = PH_HEADER;
        w_acc = '0;
        w_cmds_left = '0;
        w_next_cmd = '0;
        w_sects_left = '0;
        w_rec_idx = '0;
        w_match = 1'b1;
        w_found = 1'b0;
        w_off = '0;
        w_size = '0;
        w_addr = '0;
        w_status = ST_FOUND;
    endtask

    task automatic end_walk(input logic [1:0] st);
        w_phase = PH_END;
        w_status = st;
    endtask

    task automatic name_cmp(input logic [47:0] nm, input int k, input logic [7:0] b);
        if (k < 6) begin
            if (b != nm[8*k +: 8]) w_match = 1'b0;
        end else if (k == 6) begin
            if (b != 8'd0) w_match = 1'b0;
        end
    endtask

    task automatic close_command(input logic [63:0] pos);
        w_cmds_left--;
        if (w_cmds_left == 0 || w_next_cmd <= pos) end_walk(ST_NO_TEXT);
        else w_phase = PH_SEEK;
    endtask

    // Advance the parser by one file byte and queue the words it produces.
    task automatic extract_step(input logic [7:0] b, input logic lst);
        logic [63:0] pos;
        logic [31:0] w32;
        int          i;
        logic [63:0] d;
        t_out_word   w;
        pos = {{(64-POS_BITS){1'b0}}, w_pos};
        w_acc = {b, w_acc[63:8]};
        w32 = w_acc[63:32];
        case (w_phase)
            PH_HEADER: begin
                if (pos == 3 && w32 != MAGIC64) end_walk(ST_BAD_HDR);
                else if (pos == 7 && w32 != CPU_X86_64) end_walk(ST_BAD_HDR);
                else if (pos == 15 && w32 != FILE_EXEC) end_walk(ST_BAD_HDR);
                else if (pos == 19) w_cmds_left = w32;
                else if (pos == HDR_LEN - 1) begin
                    w_next_cmd = 64'(HDR_LEN);
                    if (w_cmds_left == 0) end_walk(ST_NO_TEXT);
                    else w_phase = PH_SEEK;
                end
            end
            PH_SEEK: begin
                if (pos == w_next_cmd) begin
                    w_phase = PH_COMMAND;
                    w_rec_idx = '0;
                end
            end
            PH_SECTION: begin
                i = w_rec_idx;
                w_rec_idx++;
                if (i < 16) name_cmp(SECT_NAME, i, b);
                if (w_match) begin
                    if (i == 39) w_addr = w_acc;
                    else if (i == 47) w_size = w_acc;
                    else if (i == 51) begin
                        w_off = w32;
                        w_found = 1'b1;
                        w_phase = PH_TEXT;
                        if (w_size == 0 || (pos >= w_off && pos - w_off >= w_size - 1))
                            end_walk(ST_FOUND);
                    end
                end
                if (w_phase == PH_SECTION && i == SECT_REC_LAST) begin
                    w_sects_left--;
                    if (w_sects_left == 0) close_command(pos);
                    else begin
                        w_rec_idx = '0;
                        w_match = 1'b1;
                    end
                end
            end
            PH_TEXT: begin
                if (pos >= w_off) begin
                    d = pos - w_off;
                    if (d < w_size) begin
                        w = '{1'b0, b, w_addr + d, ST_FOUND, 32'd0, 64'd0, 64'd0};
                        words_due.push_back(w);
                    end
                    if (d >= w_size - 1) end_walk(ST_FOUND);
                end
            end
            default: ;
        endcase

        // the seek may land on the command start in this same byte
        if (w_phase == PH_COMMAND) begin
            i = w_rec_idx;
            w_rec_idx++;
            if (i == 3) begin
                w_match = (w32 == CMD_SEGMENT64);
            end else if (i == 7) begin
                if ({32'd0, w32} > {{(64-POS_BITS){1'b0}}, POS_MASK} - w_next_cmd)
                    w_next_cmd = '0;
                else
                    w_next_cmd = w_next_cmd + w32;
                if (!w_match) close_command(pos);
            end else if (i >= 8 && i < 24) begin
                name_cmp(SEGMENT_LABEL, i - 8, b);
                if (i == 23 && !w_match) close_command(pos);
            end else if (i == 67) begin
                w_sects_left = w32;
            end else if (i == SEG_REC_LAST) begin
                if (w_sects_left == 0) close_command(pos);
                else begin
                    w_phase = PH_SECTION;
                    w_rec_idx = '0;
                    w_match = 1'b1;
                end
            end
        end

        w_pos = w_pos + 1'b1;

        if (lst) begin
            w.kind = 1'b1;
            w.text_byte = '0;
            w.text_address = '0;
            w.status = (w_phase == PH_END) ? w_status : ST_TRUNCATED;
            w.offset = w_found ? w_off : '0;
            w.size = w_found ? w_size : '0;
            w.load_address = w_found ? w_addr : '0;
            words_due.push_back(w);
            walk_reset();
        end
    endtask

    // ---------------- image builder ----------------
    task automatic put8(input int o, input logic [7:0] v);
        while (img.size() <= o) img.push_back(8'($urandom));
        img[o] = v;
    endtask

    task automatic put32(input int o, input logic [31:0] v);
        for (int k = 0; k < 4; k++) put8(o + k, v[8*k +: 8]);
    endtask

    task automatic put64(input int o, input logic [63:0] v);
        for (int k = 0; k < 8; k++) put8(o + k, v[8*k +: 8]);
    endtask

    // Name field of 16 bytes; without a terminator the seventh byte is a letter.
    task automatic put_name(input int o, input string nm, input bit term);
        for (int k = 0; k < nm.len(); k++) put8(o + k, nm[k]);
        put8(o + nm.len(), term ? 8'd0 : 8'(8'h41 + $urandom_range(0, 25)));
        if (img.size() < o + 16) put8(o + 15, 8'($urandom));
    endtask

    task automatic make_image(input int n_pre, input int pre_kind, input int seg_mode,
                              input int n_sect, input int hit, input bit hit_noterm,
                              input int txt_len, input bit early, input logic [63:0] addr);
        int cur, kind, sz, ns, base, rec_end, off, total, sb;
        img.delete();
        put32(0, MAGIC64);
        put32(4, CPU_X86_64);
        put32(12, FILE_EXEC);
        put32(16, n_pre + 1);
        put32(28, $urandom);
        cur = 32;
        for (int k = 0; k < n_pre; k++) begin
            kind = (k == 0 && pre_kind >= 0) ? pre_kind : $urandom_range(0, 2);
            case (kind)
                0: begin
                    sz = 8 * $urandom_range(1, 3);
                    put32(cur, $urandom_range(1, 17));
                    put32(cur + 4, sz);
                end
                1: begin
                    sz = 72;
                    put32(cur, CMD_SEGMENT64);
                    put32(cur + 4, sz);
                    put_name(cur + 8, "__DATA", 1);
                    put32(cur + 64, 0);
                end
                2: begin
                    // __TEXT segment with no __text section: the walk must move on
                    ns = $urandom_range(0, 2);
                    sz = 72 + 80 * ns;
                    put32(cur, CMD_SEGMENT64);
                    put32(cur + 4, sz);
                    put_name(cur + 8, "__TEXT", 1);
                    put32(cur + 64, ns);
                    for (int j = 0; j < ns; j++) put_name(cur + 72 + 80 * j, "__cstr", 1);
                end
                3: begin
                    sz = 16;
                    put32(cur, 32'd2);
                    put32(cur + 4, 32'd0);
                end
                default: begin
                    sz = 16;
                    put32(cur, 32'd2);
                    put32(cur + 4, 32'hffff_fff0);
                end
            endcase
            cur += sz;
            put8(cur - 1, 8'($urandom));
        end
        base = cur;
        rec_end = base + 72 + 80 * n_sect;
        off = early ? rec_end - $urandom_range(1, 60) : rec_end + $urandom_range(0, 5);
        put32(base, CMD_SEGMENT64);
        put32(base + 4, 72 + 80 * n_sect);
        case (seg_mode)
            0: put_name(base + 8, "__TEXT", 1);
            1: put_name(base + 8, "__TEXt", 1);
            default: put_name(base + 8, "__TEXT", 0);
        endcase
        put32(base + 64, n_sect);
        for (int s = 0; s < n_sect; s++) begin
            sb = base + 72 + 80 * s;
            if (s == hit) begin
                put_name(sb, "__text", !hit_noterm);
                put64(sb + 32, addr);
                put64(sb + 40, 64'(txt_len));
                put32(sb + 48, off);
            end else begin
                put_name(sb, "__data", 1);
            end
            put_name(sb + 16, "__TEXT", 1);
            put8(sb + 79, 8'($urandom));
        end
        total = ((off + txt_len > rec_end) ? off + txt_len : rec_end) + $urandom_range(0, 3);
        put8(total - 1, 8'($urandom));
    endtask

    task automatic cut_image(input int len);
        while (img.size() > len) void'(img.pop_back());
    endtask

    task automatic push_image(input bit drain, input bit counted);
        for (int k = 0; k < img.size(); k++)
            file_q.push_back('{img[k], k == img.size() - 1, drain && k == 0});
        if (counted) n_rand += img.size();
    endtask

    function automatic logic [63:0] rand_addr();
        return {32'($urandom), 32'($urandom)};
    endfunction

    // ---------------- stimulus ----------------
    initial begin
        int r, ns, nb;
        walk_reset();

        // header failures and short files
        make_image(0, -1, 0, 1, 0, 0, 4, 0, rand_addr()); cut_image(1);  push_image(0, 1);
        make_image(0, -1, 0, 1, 0, 0, 4, 0, rand_addr()); img[3] ^= 8'h80; cut_image(6);
        push_image(0, 1);
        make_image(0, -1, 0, 1, 0, 0, 4, 0, rand_addr()); img[4] ^= 8'h01; cut_image(10);
        push_image(0, 1);
        make_image(0, -1, 0, 1, 0, 0, 4, 0, rand_addr()); img[12] ^= 8'h03; cut_image(18);
        push_image(0, 1);
        make_image(0, -1, 0, 1, 0, 0, 4, 0, rand_addr()); cut_image(20); push_image(0, 1);
        make_image(0, -1, 0, 1, 0, 0, 4, 0, rand_addr()); put32(16, 0); cut_image(34);
        push_image(0, 1);
        // found, with the address wrapping past 2^64
        make_image(0, -1, 0, 1, 0, 0, 6, 0, 64'hffff_ffff_ffff_fffc); push_image(0, 1);
        // a section that starts before its record ends
        make_image(0, -1, 0, 1, 0, 0, 70, 1, rand_addr()); push_image(0, 1);
        // unreachable next command: zero size, size past the position range
        make_image(1, 3, 0, 1, 0, 0, 4, 0, rand_addr()); cut_image(50); push_image(0, 1);
        make_image(1, 4, 0, 1, 0, 0, 4, 0, rand_addr()); cut_image(50); push_image(0, 1);
        // __TEXT without __text ahead of the real one
        make_image(1, 2, 0, 2, 1, 0, 5, 0, rand_addr()); push_image(0, 1);

        while (n_rand < RAND_ITEMS) begin
            r = $urandom_range(0, 99);
            ns = $urandom_range(1, 3);
            nb = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 24);
            if (r < 60) begin
                make_image($urandom_range(0, 2), -1, 0, ns, $urandom_range(0, ns - 1), 0, nb,
                           $urandom_range(0, 9) == 0, rand_addr());
            end else if (r < 72) begin
                make_image($urandom_range(0, 2), $urandom_range(0, 4), $urandom_range(0, 2),
                           $urandom_range(0, 2), $urandom_range(0, 2) - 1,
                           $urandom_range(0, 3) == 0, nb, 0, rand_addr());
                cut_image($urandom_range(40, img.size()));
            end else if (r < 82) begin
                make_image($urandom_range(0, 1), -1, 0, ns, $urandom_range(0, ns - 1), 0, nb,
                           0, rand_addr());
                cut_image($urandom_range(1, img.size()));
            end else if (r < 94) begin
                make_image($urandom_range(0, 1), -1, 0, ns, $urandom_range(0, ns - 1), 0, nb,
                           0, rand_addr());
                repeat ($urandom_range(1, 3)) begin
                    nb = $urandom_range(0, img.size() - 1);
                    img[nb] ^= 8'(1 << $urandom_range(0, 7));
                end
            end else begin
                img.delete();
                repeat ($urandom_range(1, 40)) img.push_back(8'($urandom));
            end
            push_image($urandom_range(0, 19) == 0 || n_rand == 0, 1);
        end

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        wait (file_q.size() == 0 && !s_axis_tvalid);
        wait (words_due.size() == 0);
        repeat (10) @(posedge i_clk);
        if (n_err == 0) $display("tb: done, clean");
        else $display("tb: done, errors");
        $finish;
    end

    // ---------------- driver ----------------
    int tx_gap = 0;

    task automatic pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (p < 70) tx_gap = 0;
        else if (p < 94) tx_gap = $urandom_range(1, 3);
        else tx_gap = $urandom_range(10, 40);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) extract_step(s_axis_tdata, s_axis_tlast);
            if (!(s_axis_tvalid && !s_axis_tready)) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                    s_axis_tvalid <= 1'b0;
                end else if (file_q.size() == 0 ||
                             (file_q[0].drain && words_due.size() != 0)) begin
                    // hold until the extractor has delivered everything owed
                    s_axis_tvalid <= 1'b0;
                end else begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= file_q[0].b;
                    s_axis_tlast <= file_q[0].lst;
                    void'(file_q.pop_front());
                    if ((cyc % 1024) < 200) tx_gap = 0;
                    else begin
                        pick_gap();
                    end
                end
            end
        end
    end

    // ---------------- monitor ----------------
    int rx_stall = 0;

    always @(posedge i_clk) begin
        t_out_word  e;
        logic [1:0] a_status;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                a_status = m_axis_tdata[73:72];
                if (words_due.size() == 0) begin
                    n_err++;
                    $display("%0t: unexpected word kind=%0d data=%h", $time, m_axis_tuser,
                             m_axis_tdata[233:0]);
                end else begin
                    e = words_due.pop_front();
                    if (m_axis_tuser !== e.kind || m_axis_tdata[7:0] !== e.text_byte ||
                        m_axis_tdata[71:8] !== e.text_address || a_status !== e.status ||
                        m_axis_tdata[105:74] !== e.offset ||
                        m_axis_tdata[169:106] !== e.size ||
                        m_axis_tdata[233:170] !== e.load_address) begin
                        n_err++;
                        $display("%0t: mismatch exp kind=%0d byte=%h addr=%h st=%0d off=%h size=%h load=%h",
                                 $time, e.kind, e.text_byte, e.text_address, e.status,
                                 e.offset, e.size, e.load_address);
                        $display("%0t:          got kind=%0d byte=%h addr=%h st=%0d off=%h size=%h load=%h",
                                 $time, m_axis_tuser, m_axis_tdata[7:0], m_axis_tdata[71:8],
                                 a_status, m_axis_tdata[105:74], m_axis_tdata[169:106],
                                 m_axis_tdata[233:170]);
                    end
                end
            end
            if (rx_stall > 0) begin
                rx_stall--;
                m_axis_tready <= 1'b0;
            end else if ((cyc % 1024) >= 600 && (cyc % 1024) < 800) begin
                m_axis_tready <= 1'b1;
            end else if ($urandom_range(0, 99) < 25) begin
                rx_stall = ($urandom_range(0, 99) < 90) ? $urandom_range(0, 2)
                                                         : $urandom_range(10, 40);
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // ---------------- watchdog ----------------
    always @(posedge i_clk) begin
        cyc++;
        if (cyc > LIMIT_CYCLES) begin
            $display("tb: done, errors");
            $finish;
        end
    end

endmodule
